FILE: design/cpds_pkg.sv
// Shared types, codes and helpers for the clamped pixel depth store.
package cpds_pkg;

    // Request codes
    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_PACKED = 2'd3;

    // Configuration register indexes
    localparam logic CFG_X_RES = 1'b0;
    localparam logic CFG_Y_RES = 1'b1;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic [8:0]  RES_RESET  = 9'd256;
    localparam logic [11:0] COLOUR_MAX = 12'd4095;
    localparam logic [11:0] CLEAR_GREY = 12'd2048;
    localparam logic [15:0] CLEAR_ALPHA = 16'd1;
    localparam logic [31:0] DEPTH_MAX  = 32'h7FFF_FFFF;
    localparam int          PACK_SHIFT = 4;

    // Index arithmetic width: x + y * w with x, y, w all below 512
    localparam int IDX_W = 18;

    typedef struct packed {
        logic [11:0] red;
        logic [11:0] green;
        logic [11:0] blue;
        logic [15:0] alpha;
        logic [31:0] depth;
    } pixel_t;

    localparam pixel_t CLEAR_PIXEL = '{
        red:   CLEAR_GREY,
        green: CLEAR_GREY,
        blue:  CLEAR_GREY,
        alpha: CLEAR_ALPHA,
        depth: DEPTH_MAX
    };

    // Saturate a signed 16-bit intensity to 0..4095
    function automatic logic [11:0] clamp_colour(input logic signed [15:0] c);
        logic [11:0] r;
        if (c[15])
            r = 12'd0;
        else if (c > $signed({4'd0, COLOUR_MAX}))
            r = COLOUR_MAX;
        else
            r = c[11:0];
        return r;
    endfunction

    // 8-bit scan-out value of a 12-bit intensity
    function automatic logic [7:0] pack_colour(input logic [11:0] c);
        logic [11:0] s;
        s = c >> PACK_SHIFT;
        return s[7:0];
    endfunction

endpackage

FILE: design/cpds_decode.sv
// Request decode: effective frame size, range check, pixel index and clear extent.
module cpds_decode
    import cpds_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int AW         = 16
)
(
    input  logic [8:0]        x_res,
    input  logic [8:0]        y_res,
    input  logic signed [9:0] x,
    input  logic signed [9:0] y,
    output logic              oor,
    output logic [AW-1:0]     addr,
    output logic [AW-1:0]     area_last
);

    logic [12:0]      xr_w;
    logic [12:0]      yr_w;
    logic [12:0]      w_w;
    logic [12:0]      h_w;
    logic [8:0]       w;
    logic [8:0]       h;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] area;

    // Zero counts as one, anything above the maximum as the maximum
    always_comb
    begin
        xr_w = 13'(x_res);
        yr_w = 13'(y_res);
        if (xr_w == 13'd0)
            w_w = 13'd1;
        else if (xr_w > 13'(MAX_WIDTH))
            w_w = 13'(MAX_WIDTH);
        else
            w_w = xr_w;
        if (yr_w == 13'd0)
            h_w = 13'd1;
        else if (yr_w > 13'(MAX_HEIGHT))
            h_w = 13'(MAX_HEIGHT);
        else
            h_w = yr_w;
        w = w_w[8:0];
        h = h_w[8:0];
    end

    assign oor = x[9] || y[9] || (x[8:0] >= w) || (y[8:0] >= h);

    // In range, x + y * w stays below w * h, which fits the store
    assign idx       = IDX_W'(x[8:0]) + IDX_W'(y[8:0]) * IDX_W'(w);
    assign area      = IDX_W'(w) * IDX_W'(h);
    assign addr      = AW'(idx);
    assign area_last = AW'(area - IDX_W'(1));

endmodule

FILE: design/cpds_mem.sv
// Pixel memory: one write port, one read port with registered read data.
module cpds_mem
    import cpds_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
    parameter int AW    = 16
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  pixel_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output pixel_t        rdata
);

    pixel_t store_mem [DEPTH];
    pixel_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            store_mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= store_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/clamped_pixel_depth_store.sv
// Top level of the clamped pixel depth store: control, config registers, result register.
//
//  channel  direction  handshake                  payload
//  in       input      in_valid / in_stall        req_type x y red_in green_in blue_in
//                                                 alpha_in depth_in
//  out      output     out_valid / out_stall      status red_out green_out blue_out
//                                                 alpha_out depth_out packed_*
//  cfg      input      cfg_we (index, data)       x_res (0), y_res (1), 9 bits each
//
//  A write or out-of-range request passes through S_EXEC, a read or packed read through
//  S_EXEC and S_RESP, a clear through S_EXEC and the one-pixel-per-cycle S_CLEAR sweep,
//  all on the single memory port pair; one item is in work at a time.
//  Reset clears control state and sets x_res and y_res to 256; memory is not cleared.
//  A result waits in the output register while out_stall is high; the next item is
//  taken meanwhile, and its own result holds in the work stage until the register frees.
module clamped_pixel_depth_store
    import cpds_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [8:0]         cfg_data,
    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic signed [9:0]  x,
    input  logic signed [9:0]  y,
    input  logic signed [15:0] red_in,
    input  logic signed [15:0] green_in,
    input  logic signed [15:0] blue_in,
    input  logic signed [15:0] alpha_in,
    input  logic signed [31:0] depth_in,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic               status,
    output logic [11:0]        red_out,
    output logic [11:0]        green_out,
    output logic [11:0]        blue_out,
    output logic signed [15:0] alpha_out,
    output logic signed [31:0] depth_out,
    output logic [7:0]         packed_blue,
    output logic [7:0]         packed_green,
    output logic [7:0]         packed_red
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Control states
    localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for an item
    localparam logic [1:0] S_EXEC  = 2'd1;  // write, range error, read issue or clear start
    localparam logic [1:0] S_RESP  = 2'd2;  // read data back from memory
    localparam logic [1:0] S_CLEAR = 2'd3;  // clear sweep, one pixel a cycle until the last

    logic [1:0]    state_reg, state_next;
    logic [8:0]    x_res_reg, y_res_reg;
    logic          out_valid_reg, out_valid_next;

    // Item held for the work stage
    logic [1:0]    req_reg;
    logic          oor_reg;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] area_last_reg;
    pixel_t        wpix_reg;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    // Result register
    logic          status_reg;
    pixel_t        res_pix_reg;
    logic [7:0]    pk_blue_reg, pk_green_reg, pk_red_reg;

    logic          dec_oor;
    logic [AW-1:0] dec_addr;
    logic [AW-1:0] dec_area_last;

    logic          in_take;
    logic          slot_free;
    logic          out_load;
    logic          res_status;
    pixel_t        res_pix;
    logic [7:0]    res_pk_blue, res_pk_green, res_pk_red;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    pixel_t        mem_wdata;
    logic          mem_re;
    pixel_t        mem_rdata;

    cpds_decode #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_decode (
        .x_res     (x_res_reg),
        .y_res     (y_res_reg),
        .x         (x),
        .y         (y),
        .oor       (dec_oor),
        .addr      (dec_addr),
        .area_last (dec_area_last)
    );

    // Items never overlap, so a read is always issued after the write it depends on
    // has been done: no forwarding is needed.
    cpds_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_res_reg <= RES_RESET;
            y_res_reg <= RES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_X_RES: x_res_reg <= cfg_data;
                CFG_Y_RES: y_res_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Control FSM and result selection
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        mem_we       = 1'b0;
        mem_waddr    = addr_reg;
        mem_wdata    = wpix_reg;
        mem_re       = 1'b0;
        out_load     = 1'b0;
        res_status   = 1'b0;
        res_pix      = '0;
        res_pk_blue  = 8'd0;
        res_pk_green = 8'd0;
        res_pk_red   = 8'd0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (req_reg == REQ_CLEAR)
                begin
                    clr_cnt_next = '0;
                    state_next   = S_CLEAR;
                end
                else if (oor_reg)
                begin
                    res_status = 1'b1;
                    if (slot_free)
                    begin
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (req_reg == REQ_WRITE)
                begin
                    if (slot_free)
                    begin
                        mem_we     = 1'b1;
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                // read data holds: no other read is issued until we leave
                if (req_reg == REQ_READ)
                    res_pix = mem_rdata;
                else
                begin
                    res_pk_blue  = pack_colour(mem_rdata.blue);
                    res_pk_green = pack_colour(mem_rdata.green);
                    res_pk_red   = pack_colour(mem_rdata.red);
                end
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                // rewriting the last pixel while the result waits is harmless
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = CLEAR_PIXEL;
                if (clr_cnt_reg == area_last_reg)
                begin
                    if (slot_free)
                    begin
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                    clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            default:
                state_next = S_IDLE;
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        clr_cnt_reg <= clr_cnt_next;
        if (in_take)
        begin
            req_reg        <= req_type;
            oor_reg        <= dec_oor;
            addr_reg       <= dec_addr;
            area_last_reg  <= dec_area_last;
            wpix_reg.red   <= clamp_colour(red_in);
            wpix_reg.green <= clamp_colour(green_in);
            wpix_reg.blue  <= clamp_colour(blue_in);
            wpix_reg.alpha <= alpha_in;
            wpix_reg.depth <= depth_in;
        end
        if (out_load)
        begin
            status_reg   <= res_status;
            res_pix_reg  <= res_pix;
            pk_blue_reg  <= res_pk_blue;
            pk_green_reg <= res_pk_green;
            pk_red_reg   <= res_pk_red;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign red_out      = res_pix_reg.red;
    assign green_out    = res_pix_reg.green;
    assign blue_out     = res_pix_reg.blue;
    assign alpha_out    = res_pix_reg.alpha;
    assign depth_out    = res_pix_reg.depth;
    assign packed_blue  = pk_blue_reg;
    assign packed_green = pk_green_reg;
    assign packed_red   = pk_red_reg;

`ifndef SYNTHESIS
    // Memory is written only by a write request or the clear sweep
    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR) || (state_reg == S_EXEC && req_reg == REQ_WRITE))
        else $error("memory write outside a write or clear");

    // Clear sweep never runs past the configured frame
    a_clr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (clr_cnt_reg <= area_last_reg))
        else $error("clear sweep beyond frame");

    // A taken item always leaves idle
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == S_EXEC))
        else $error("accepted item not in work");

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten");
`endif

endmodule

FILE: verif/pixel_store_checker.sv
// Checker for the clamped pixel depth store: frame mirror, expected-reply queue and compare.
module pixel_store_checker
    import cpds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [8:0]         cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic signed [9:0]  x,
    input  logic signed [9:0]  y,
    input  logic signed [15:0] red_in,
    input  logic signed [15:0] green_in,
    input  logic signed [15:0] blue_in,
    input  logic signed [15:0] alpha_in,
    input  logic signed [31:0] depth_in,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               status,
    input  logic [11:0]        red_out,
    input  logic [11:0]        green_out,
    input  logic [11:0]        blue_out,
    input  logic signed [15:0] alpha_out,
    input  logic signed [31:0] depth_out,
    input  logic [7:0]         packed_blue,
    input  logic [7:0]         packed_green,
    input  logic [7:0]         packed_red,
    output int unsigned        pending_results,
    output int                 fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               status;
        logic [11:0]        red;
        logic [11:0]        green;
        logic [11:0]        blue;
        logic signed [15:0] alpha;
        logic signed [31:0] depth;
        logic [7:0]         pk_blue;
        logic [7:0]         pk_green;
        logic [7:0]         pk_red;
    } pixel_reply_t;

    pixel_t       frame_mirror [DEF_MAX_WIDTH * DEF_MAX_HEIGHT];
    pixel_reply_t expected_replies [$];
    logic [8:0]   width_reg;
    logic [8:0]   height_reg;

    initial fail_count = 0;

    function automatic logic [11:0] saturate_level(input logic signed [15:0] v);
        if (v < 0)
            return '0;
        if (int'(v) > int'(COLOUR_MAX))
            return COLOUR_MAX;
        return v[11:0];
    endfunction

    // Applies one request to the mirror and returns the reply it should produce.
    function automatic pixel_reply_t predict_reply(
        input logic [1:0]         kind,
        input logic signed [9:0]  col,
        input logic signed [9:0]  row,
        input logic signed [15:0] r,
        input logic signed [15:0] g,
        input logic signed [15:0] b,
        input logic signed [15:0] a,
        input logic signed [31:0] d
    );
        pixel_reply_t reply;
        pixel_t       grey;
        int           w;
        int           h;
        int           idx;
        int           k;
        reply = '0;
        w = (width_reg == 0) ? 1 : ((width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : ((height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height_reg);
        if (kind == REQ_CLEAR)
        begin
            grey.red   = CLEAR_GREY;
            grey.green = CLEAR_GREY;
            grey.blue  = CLEAR_GREY;
            grey.alpha = CLEAR_ALPHA;
            grey.depth = DEPTH_MAX;
            for (k = 0; k < w * h; k++)
                frame_mirror[k] = grey;
            return reply;
        end
        if (col < 0 || int'(col) >= w || row < 0 || int'(row) >= h)
        begin
            reply.status = 1'b1;
            return reply;
        end
        idx = int'(col) + int'(row) * w;
        if (idx >= DEF_MAX_WIDTH * DEF_MAX_HEIGHT)
            idx = DEF_MAX_WIDTH * DEF_MAX_HEIGHT - 1;
        case (kind)
            REQ_WRITE:
            begin
                frame_mirror[idx].red   = saturate_level(r);
                frame_mirror[idx].green = saturate_level(g);
                frame_mirror[idx].blue  = saturate_level(b);
                frame_mirror[idx].alpha = a;
                frame_mirror[idx].depth = d;
            end
            REQ_READ:
            begin
                reply.red   = frame_mirror[idx].red;
                reply.green = frame_mirror[idx].green;
                reply.blue  = frame_mirror[idx].blue;
                reply.alpha = frame_mirror[idx].alpha;
                reply.depth = frame_mirror[idx].depth;
            end
            default:
            begin
                reply.pk_blue  = frame_mirror[idx].blue[11:4];
                reply.pk_green = frame_mirror[idx].green[11:4];
                reply.pk_red   = frame_mirror[idx].red[11:4];
            end
        endcase
        return reply;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_reply_t want;
        if (!rst_n)
        begin
            width_reg  <= RES_RESET;
            height_reg <= RES_RESET;
            expected_replies.delete();
            pending_results <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_X_RES)
                    width_reg <= cfg_data;
                else
                    height_reg <= cfg_data;
            end
            // compare before queuing: a reply never leaves in the cycle its item enters
            if (out_valid && !out_stall)
            begin
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: reply with no request outstanding", $time);
                    fail_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("status", want.status, status);
                    check_field("red_out", want.red, red_out);
                    check_field("green_out", want.green, green_out);
                    check_field("blue_out", want.blue, blue_out);
                    check_field("alpha_out", want.alpha, alpha_out);
                    check_field("depth_out", want.depth, depth_out);
                    check_field("packed_blue", want.pk_blue, packed_blue);
                    check_field("packed_green", want.pk_green, packed_green);
                    check_field("packed_red", want.pk_red, packed_red);
                end
            end
            if (in_valid && !in_stall)
                expected_replies.push_back(predict_reply(req_type, x, y, red_in, green_in,
                                                         blue_in, alpha_in, depth_in));
            pending_results <= expected_replies.size();
        end
    end

endmodule

FILE: verif/tb_clamped_pixel_depth_store.sv
// Top of the pixel depth store testbench: clock, reset, request and reply traffic, verdict.
module tb_clamped_pixel_depth_store
    import cpds_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Long reply hold-off, long enough to back the block up into its input.
    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 75;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = CFG_X_RES;
    logic [8:0]         cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         req_type = REQ_WRITE;
    logic signed [9:0]  x = '0;
    logic signed [9:0]  y = '0;
    logic signed [15:0] red_in = '0;
    logic signed [15:0] green_in = '0;
    logic signed [15:0] blue_in = '0;
    logic signed [15:0] alpha_in = '0;
    logic signed [31:0] depth_in = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               status;
    logic [11:0]        red_out;
    logic [11:0]        green_out;
    logic [11:0]        blue_out;
    logic signed [15:0] alpha_out;
    logic signed [31:0] depth_out;
    logic [7:0]         packed_blue;
    logic [7:0]         packed_green;
    logic [7:0]         packed_red;
    int unsigned        pending_results;
    int                 fail_count;

    // Traffic shaping knobs, set by the stimulus process.
    bit src_idle  = 1'b1;
    bit sink_idle = 1'b1;
    bit sink_hold = 1'b0;

    // Effective frame size in use, and the last pixel written (for read-after-write).
    int                cur_w = DEF_MAX_WIDTH;
    int                cur_h = DEF_MAX_HEIGHT;
    logic signed [9:0] last_col = '0;
    logic signed [9:0] last_row = '0;
    bit                have_last = 1'b0;

    clamped_pixel_depth_store dut (.*);

    pixel_store_checker u_pixel_check (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Reply side: random stall bursts, plus one long hold-off on request.
    always
    begin
        @(posedge clk);
        if (sink_hold)
        begin
            out_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            sink_hold = 1'b0;
            out_stall <= 1'b0;
        end
        else if (sink_idle && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    // Offers one item and returns at the edge where it is taken. The valid stays
    // high; whatever comes next drives it again in that same step.
    task automatic issue(
        input logic [1:0]         kind,
        input logic signed [9:0]  col,
        input logic signed [9:0]  row,
        input logic signed [15:0] r,
        input logic signed [15:0] g,
        input logic signed [15:0] b,
        input logic signed [15:0] a,
        input logic signed [31:0] d
    );
        if (src_idle && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        x        <= col;
        y        <= row;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        alpha_in <= a;
        depth_in <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop offering and wait until every reply is back, since every request gives
    // one, before the registers are touched.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (4) @(posedge clk);
    endtask

    // Set the frame size. With alt_code, a width or height of 1 is written as 0
    // and 256 as 511, both of which the block must treat as the nearest legal size.
    task automatic set_frame(input int w, input int h, input bit alt_code);
        logic [8:0] w_code;
        logic [8:0] h_code;
        w_code = 9'(w);
        h_code = 9'(h);
        if (alt_code && w == 1)
            w_code = '0;
        if (alt_code && w == DEF_MAX_WIDTH)
            w_code = 9'h1FF;
        if (alt_code && h == 1)
            h_code = '0;
        if (alt_code && h == DEF_MAX_HEIGHT)
            h_code = 9'h1FF;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_X_RES;
        cfg_data  <= w_code;
        @(posedge clk);
        cfg_index <= CFG_Y_RES;
        cfg_data  <= h_code;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    // Colour levels: full 16-bit range, the legal range, and the clamp edges.
    function automatic logic signed [15:0] random_level();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 4095));
            2: return ($urandom_range(0, 1) != 0) ? 16'sd4096 : -16'sd1;
            default: return 16'($urandom_range(4000, 4200));
        endcase
    endfunction

    // Mostly inside the frame, sometimes just past an edge, sometimes anywhere.
    function automatic logic signed [9:0] random_coord(input int span);
        case ($urandom_range(0, 9))
            0: return 10'($urandom);
            1: return ($urandom_range(0, 1) != 0) ? 10'(span) : -10'sd1;
            default: return 10'($urandom_range(0, span - 1));
        endcase
    endfunction

    task automatic random_request();
        logic [1:0]        kind;
        logic signed [9:0] col;
        logic signed [9:0] row;
        int                roll;
        roll = $urandom_range(0, 99);
        // a clear sweeps the whole frame, so only small frames get them
        if (roll < 4 && cur_w * cur_h <= 256)
            kind = REQ_CLEAR;
        else if (roll < 45)
            kind = REQ_WRITE;
        else if (roll < 75)
            kind = REQ_READ;
        else
            kind = REQ_PACKED;
        // reads often go back to the pixel last written
        if (have_last && kind != REQ_WRITE && $urandom_range(0, 9) < 5)
        begin
            col = last_col;
            row = last_row;
        end
        else
        begin
            col = random_coord(cur_w);
            row = random_coord(cur_h);
        end
        if (kind == REQ_WRITE)
        begin
            last_col  = col;
            last_row  = row;
            have_last = 1'b1;
        end
        issue(kind, col, row, random_level(), random_level(), random_level(),
              16'($urandom), 32'($urandom));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-size clear first: from here on every pixel holds a defined value.
        set_frame(DEF_MAX_WIDTH, DEF_MAX_HEIGHT, 1'b0);
        issue(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0);

        // Clamp edges and field extremes at the frame corners.
        issue(REQ_WRITE, 0, 0, -16'sd32768, 16'sd4096, 16'sd4095, -16'sd32768, 32'h8000_0000);
        issue(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
        issue(REQ_PACKED, 0, 0, 0, 0, 0, 0, 0);
        issue(REQ_WRITE, 255, 255, 16'sd32767, -16'sd1, 16'sd0, 16'sd32767, 32'h7FFF_FFFF);
        issue(REQ_READ, 255, 255, 0, 0, 0, 0, 0);
        issue(REQ_PACKED, 255, 255, 0, 0, 0, 0, 0);
        // Out-of-range coordinates on every side; none may change the frame.
        issue(REQ_WRITE, 256, 0, 16'sd100, 16'sd100, 16'sd100, 16'sd5, 32'd5);
        issue(REQ_READ, -1, 5, 0, 0, 0, 0, 0);
        issue(REQ_READ, 5, -512, 0, 0, 0, 0, 0);
        issue(REQ_PACKED, 511, 511, 0, 0, 0, 0, 0);
        issue(REQ_WRITE, -512, 0, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 32'd1);
        // Untouched pixel still shows the clear grey.
        issue(REQ_READ, 17, 3, 0, 0, 0, 0, 0);
        issue(REQ_PACKED, 17, 3, 0, 0, 0, 0, 0);

        // Zero-sized registers behave as a single pixel.
        drain_results();
        set_frame(1, 1, 1'b1);
        issue(REQ_WRITE, 0, 0, 16'sd1234, 16'sd4095, 16'sd16, 16'sd7, 32'd99);
        issue(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
        issue(REQ_READ, 1, 0, 0, 0, 0, 0, 0);
        issue(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        issue(REQ_READ, 0, 0, 0, 0, 0, 0, 0);

        // Oversized registers saturate to the full frame.
        drain_results();
        set_frame(DEF_MAX_WIDTH, DEF_MAX_HEIGHT, 1'b1);
        issue(REQ_READ, 255, 255, 0, 0, 0, 0, 0);
        issue(REQ_PACKED, 255, 0, 0, 0, 0, 0, 0);

        // A clear covers only width * height pixels: widen afterwards and look past it.
        drain_results();
        set_frame(4, 3, 1'b0);
        issue(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        drain_results();
        set_frame(8, 8, 1'b0);
        issue(REQ_READ, 0, 2, 0, 0, 0, 0, 0);
        issue(REQ_READ, 3, 2, 0, 0, 0, 0, 0);

        // Random phases, each with its own frame size.
        for (int phase = 0; phase < 8; phase++)
        begin
            drain_results();
            case (phase)
                1: set_frame(DEF_MAX_WIDTH, DEF_MAX_HEIGHT, 1'b1);
                3: set_frame(1, 1, 1'b1);
                5: set_frame(DEF_MAX_WIDTH, 1, 1'($urandom_range(0, 1)));
                default: set_frame($urandom_range(1, 20), $urandom_range(1, 12),
                                   1'($urandom_range(0, 1)));
            endcase
            // the last two phases run at full rate on both sides
            src_idle  = (phase < 6);
            sink_idle = (phase < 6);
            if (phase == 2)
                sink_hold = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // pause the sender mid-phase until every reply is back
                if (phase == 4 && n == 40)
                    drain_results();
                random_request();
            end
        end

        drain_results();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, including the full-frame clear.
    initial
    begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
design/cpds_pkg.sv
design/cpds_decode.sv
design/cpds_mem.sv
design/clamped_pixel_depth_store.sv
verif/pixel_store_checker.sv
verif/tb_clamped_pixel_depth_store.sv
